// ===== hdl/srs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sagging rope sampler package
// Shared types, command and status codes and fixed constants.
// ----------------------------------------------------------------------------
package srs_pkg;

    // Q0.32 forms of 0.03 and 0.05.
    localparam logic [26:0] K_003 = 27'd128849019;
    localparam logic [27:0] K_005 = 28'd214748365;

    // Operand widths of the shared multiplier.
    localparam int MUL_A_W = 68;
    localparam int MUL_B_W = 35;

    // Horner accumulator width and divider dividend width.
    localparam int H_W   = 58;
    localparam int DIV_W = 58;

    localparam logic [1:0] AXIS_LAST = 2'd2;
    localparam logic [2:0] STEP_LAST = 3'd5;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
        logic signed [31:0] sag_x;
        logic signed [31:0] sag_y;
        logic signed [31:0] sag_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
    } t_in;

    typedef struct packed {
        logic        [5:0]  sample_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               last_sample;
    } t_out;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQ_S,
        S_SQ_W,
        S_RT_S,
        S_RT_W,
        S_D3_S,
        S_D3_W,
        S_SAG_S,
        S_SAG_W,
        S_VEL_S,
        S_VEL_W,
        S_ENDS,
        S_H_S,
        S_H_W,
        S_DIV_S,
        S_DIV_W,
        S_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ_START,
        OP_SQ_TAKE,
        OP_RT_START,
        OP_RT_TAKE,
        OP_D3_START,
        OP_D3_TAKE,
        OP_SAG_START,
        OP_SAG_TAKE,
        OP_VEL_START,
        OP_VEL_TAKE,
        OP_ENDS,
        OP_H_START,
        OP_H_TAKE,
        OP_DIV_START,
        OP_DIV_TAKE,
        OP_NEXT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] axis;
        logic [2:0] step;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic rt_done;
        logic div_done;
        logic last;
    } t_status;

endpackage

// ===== hdl/srs_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sagging rope sampler multiplier
// Shift-and-add multiplier, signed by unsigned, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module srs_mul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [srs_pkg::MUL_A_W-1:0] i_a,
    input  logic        [srs_pkg::MUL_B_W-1:0] i_b,
    output logic signed [srs_pkg::MUL_A_W-1:0] o_p,
    output logic                             o_done
);
    import srs_pkg::*;

    logic                      r_busy;
    logic signed [MUL_A_W-1:0] r_acc;
    logic signed [MUL_A_W-1:0] r_a;
    logic        [MUL_B_W-1:0] r_b;

    // Finishes as soon as no multiplier bits remain, so short operands are quick.
    assign o_done = r_busy && (r_b == '0);
    assign o_p    = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_busy && (r_b != '0)) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a <<< 1;
            r_b <= r_b >> 1;
        end
    end

endmodule

// ===== hdl/srs_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sagging rope sampler square root
// Digit-by-digit floor square root, one result bit a cycle.
// ----------------------------------------------------------------------------
module srs_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [67:0] i_rad,
    output logic [34:0] o_root,
    output logic        o_done
);
    import srs_pkg::*;

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [69:0] r_rad;
    logic [36:0] r_rem;
    logic [34:0] r_root;
    logic [38:0] w_rem2;
    logic [38:0] w_trial;
    logic        w_ge;

    assign o_done  = r_busy && (r_cnt == 6'd0);
    assign o_root  = r_root;
    assign w_rem2  = {r_rem, r_rad[69:68]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ge    = (w_rem2 >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 6'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd35;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= {2'b00, i_rad};
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy && (r_cnt != 6'd0)) begin
            r_rad  <= {r_rad[67:0], 2'b00};
            r_rem  <= w_ge ? 37'(w_rem2 - w_trial) : w_rem2[36:0];
            r_root <= {r_root[33:0], w_ge};
        end
    end

endmodule

// ===== hdl/srs_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sagging rope sampler divider
// Restoring divider for the low 33 quotient bits, with a flag for larger quotients.
// ----------------------------------------------------------------------------
module srs_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [srs_pkg::DIV_W-1:0]     i_num,
    input  logic [18:0]                   i_den,
    output logic [32:0]                   o_q,
    output logic                          o_big,
    output logic                          o_done
);
    import srs_pkg::*;

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [18:0] r_den;
    logic [18:0] r_rem;
    logic [32:0] r_num;
    logic [32:0] r_q;
    logic        r_big;
    logic [19:0] w_trial;
    logic        w_ge;

    assign o_done  = r_busy && (r_cnt == 6'd0);
    assign o_q     = r_q;
    assign o_big   = r_big;
    assign w_trial = {r_rem, r_num[32]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 6'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd33;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
        end
    end

    // When the top part already reaches the divisor the quotient is at
    // least 2^33 and saturates, so the remaining bits are not needed.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_big <= (i_num[DIV_W-1:33] >= {6'd0, i_den});
            r_rem <= i_num[51:33];
            r_num <= i_num[32:0];
            r_q   <= '0;
        end else if (r_busy && (r_cnt != 6'd0)) begin
            r_rem <= w_ge ? 19'(w_trial - {1'b0, r_den}) : w_trial[18:0];
            r_num <= {r_num[31:0], 1'b0};
            r_q   <= {r_q[31:0], w_ge};
        end
    end

endmodule

// ===== hdl/srs_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sagging rope sampler datapath
// Control point set-up, Horner evaluation of the spans and rounding division.
// ----------------------------------------------------------------------------
module srs_dp #(
    parameter int MAX_SEGMENTS = 64,
    parameter int COORD_BITS   = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  srs_pkg::t_cmd    i_cmd,
    output srs_pkg::t_status o_status,
    input  logic             i_cfg_we,
    input  logic [6:0]       i_cfg_wdata,
    input  srs_pkg::t_in     i_in_data,
    output srs_pkg::t_out    o_out_data
);
    import srs_pkg::*;

    localparam int CW        = (COORD_BITS < 32) ? COORD_BITS : 32;
    localparam int SEG_LIMIT = (MAX_SEGMENTS < 64) ? MAX_SEGMENTS : 64;
    localparam logic signed [59:0] SAT_HI = (60'sd1 <<< (CW - 1)) - 60'sd1;
    localparam logic signed [59:0] SAT_LO = -SAT_HI - 60'sd1;

    function automatic logic signed [31:0] f_sat(input logic signed [59:0] v);
        logic signed [59:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI;
        end else if (v < SAT_LO) begin
            r = SAT_LO;
        end else begin
            r = v;
        end
        return r[31:0];
    endfunction

    logic        [6:0]  r_seg;
    t_in                r_in;
    logic        [67:0] r_ss;
    logic        [34:0] r_dist;
    logic        [29:0] r_d3;
    logic signed [49:0] r_mid;
    logic signed [31:0] r_cp [0:4][0:2];
    logic        [5:0]  r_nm1;
    logic        [11:0] r_d2;
    logic        [17:0] r_d3c;
    logic        [5:0]  r_idx;
    logic signed [H_W-1:0] r_h;
    logic               r_neg;
    logic signed [31:0] r_pos [0:2];

    logic signed [31:0] w_st [0:2];
    logic signed [31:0] w_en [0:2];
    logic signed [31:0] w_sg [0:2];
    logic signed [31:0] w_vl [0:2];
    logic [1:0]         w_ax;
    logic signed [32:0] w_dx;
    logic [32:0]        w_dmag;
    logic [6:0]         w_n;
    logic [5:0]         w_d;
    logic [11:0]        w_d2;
    logic [17:0]        w_d3c;
    logic [6:0]         w_two_i;
    logic               w_first;
    logic [5:0]         w_apar;
    logic signed [31:0] w_q0, w_q1, w_q2, w_q3;
    logic signed [39:0] w_ca, w_cb, w_cc;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic        [MUL_B_W-1:0] w_mul_b;
    logic                      w_mul_start;
    logic signed [MUL_A_W-1:0] w_mul_p;
    logic                      w_mul_done;
    logic signed [MUL_A_W-1:0] w_rnd32;
    logic signed [MUL_A_W-1:0] w_rnd16;
    logic signed [33:0] w_half;
    logic signed [49:0] w_d3s;
    logic [34:0]        w_root;
    logic               w_rt_done;
    logic signed [H_W-1:0] w_hmag;
    logic [DIV_W-1:0]   w_num;
    logic [32:0]        w_q;
    logic               w_big;
    logic               w_div_done;
    logic signed [59:0] w_q60;

    assign w_ax = i_cmd.axis;

    always_comb begin
        w_st[0] = r_in.start_x;
        w_st[1] = r_in.start_y;
        w_st[2] = r_in.start_z;
        w_en[0] = r_in.end_x;
        w_en[1] = r_in.end_y;
        w_en[2] = r_in.end_z;
        w_sg[0] = r_in.sag_x;
        w_sg[1] = r_in.sag_y;
        w_sg[2] = r_in.sag_z;
        w_vl[0] = r_in.vel_x;
        w_vl[1] = r_in.vel_y;
        w_vl[2] = r_in.vel_z;
    end

    assign w_dx   = 33'(w_en[w_ax]) - 33'(w_st[w_ax]);
    assign w_dmag = w_dx[32] ? 33'(-w_dx) : w_dx;

    // Sample count clamped to the supported range.
    always_comb begin
        if (r_seg < 7'd2) begin
            w_n = 7'd2;
        end else if (r_seg > 7'(SEG_LIMIT)) begin
            w_n = 7'(SEG_LIMIT);
        end else begin
            w_n = r_seg;
        end
    end
    assign w_d   = 6'(w_n - 7'd1);
    assign w_d2  = {6'd0, w_d} * {6'd0, w_d};
    assign w_d3c = {6'd0, w_d2} * {12'd0, w_d};

    // Span selection and local parameter of the current sample.
    assign w_two_i = {r_idx, 1'b0};
    assign w_first = (w_two_i < {1'b0, r_nm1});
    assign w_apar  = w_first ? w_two_i[5:0] : 6'(w_two_i - {1'b0, r_nm1});

    always_comb begin
        if (w_first) begin
            w_q0 = r_cp[0][w_ax];
            w_q1 = r_cp[1][w_ax];
            w_q2 = r_cp[2][w_ax];
            w_q3 = r_cp[3][w_ax];
        end else begin
            w_q0 = r_cp[1][w_ax];
            w_q1 = r_cp[2][w_ax];
            w_q2 = r_cp[3][w_ax];
            w_q3 = r_cp[4][w_ax];
        end
        w_ca = 40'(w_q2) - 40'(w_q0);
        w_cb = (40'(w_q0) <<< 1) - 40'sd5 * 40'(w_q1) + (40'(w_q2) <<< 2) - 40'(w_q3);
        w_cc = 40'sd3 * 40'(w_q1) - 40'(w_q0) - 40'sd3 * 40'(w_q2) + 40'(w_q3);
    end

    // Operands for the shared multiplier.
    always_comb begin
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_mul_start = 1'b0;
        case (i_cmd.op)
            OP_SQ_START: begin
                w_mul_start = 1'b1;
                w_mul_a     = {35'd0, w_dmag};
                w_mul_b     = {2'd0, w_dmag};
            end
            OP_D3_START: begin
                w_mul_start = 1'b1;
                w_mul_a     = {33'd0, r_dist};
                w_mul_b     = {8'd0, K_003};
            end
            OP_SAG_START: begin
                w_mul_start = 1'b1;
                w_mul_a     = 68'(w_sg[w_ax]);
                w_mul_b     = {5'd0, r_d3};
            end
            OP_VEL_START: begin
                w_mul_start = 1'b1;
                w_mul_a     = 68'(w_vl[w_ax]);
                w_mul_b     = {7'd0, K_005};
            end
            OP_H_START: begin
                w_mul_start = 1'b1;
                case (i_cmd.step)
                    3'd0: begin
                        w_mul_a = 68'(w_cc);
                        w_mul_b = {29'd0, w_apar};
                    end
                    3'd1: begin
                        w_mul_a = 68'(w_cb);
                        w_mul_b = {29'd0, r_nm1};
                    end
                    3'd2, 3'd4: begin
                        w_mul_a = 68'(r_h);
                        w_mul_b = {29'd0, w_apar};
                    end
                    3'd3: begin
                        w_mul_a = 68'(w_ca);
                        w_mul_b = {23'd0, r_d2};
                    end
                    3'd5: begin
                        w_mul_a = 68'(w_q1);
                        w_mul_b = {16'd0, r_d3c, 1'b0};
                    end
                    default: begin
                        w_mul_a = '0;
                        w_mul_b = '0;
                    end
                endcase
            end
            default: begin
                w_mul_start = 1'b0;
            end
        endcase
    end

    srs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_p     (w_mul_p),
        .o_done  (w_mul_done)
    );

    srs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_RT_START),
        .i_rad   (r_ss),
        .o_root  (w_root),
        .o_done  (w_rt_done)
    );

    // Rounding of the sum: |num| + d^3 over 2 d^3, sign restored afterwards.
    assign w_hmag = r_h[H_W-1] ? -r_h : r_h;
    assign w_num  = DIV_W'(w_hmag) + {40'd0, r_d3c};

    srs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_DIV_START),
        .i_num   (w_num),
        .i_den   ({r_d3c, 1'b0}),
        .o_q     (w_q),
        .o_big   (w_big),
        .o_done  (w_div_done)
    );

    assign w_rnd32 = (w_mul_p + 68'sd2147483648) >>> 32;
    assign w_rnd16 = (w_mul_p + 68'sd32768) >>> 16;
    assign w_half  = (34'(w_st[w_ax]) + 34'(w_en[w_ax]) + 34'sd1) >>> 1;
    assign w_d3s   = {20'd0, r_d3};
    assign w_q60   = {27'd0, w_q};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg <= 7'd16;
        end else if (i_cfg_we) begin
            r_seg <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 6'd0;
        end else if (i_cmd.op == OP_LOAD) begin
            r_idx <= 6'd0;
        end else if (i_cmd.op == OP_NEXT) begin
            r_idx <= r_idx + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_in  <= i_in_data;
                r_ss  <= '0;
                r_nm1 <= w_d;
                r_d2  <= w_d2;
                r_d3c <= w_d3c;
            end
            OP_SQ_TAKE: begin
                r_ss <= r_ss + unsigned'(w_mul_p);
            end
            OP_RT_TAKE: begin
                r_dist <= w_root;
            end
            OP_D3_TAKE: begin
                r_d3 <= w_rnd32[29:0];
            end
            OP_SAG_TAKE: begin
                r_mid <= 50'(w_half) - ((w_ax == 2'd1) ? w_d3s : 50'sd0)
                         - 50'(w_rnd16);
            end
            OP_VEL_TAKE: begin
                r_cp[1][w_ax] <= f_sat(60'(w_st[w_ax]));
                r_cp[2][w_ax] <= f_sat(60'(r_mid) - 60'(w_rnd32));
                r_cp[3][w_ax] <= f_sat(60'(w_en[w_ax]));
            end
            OP_ENDS: begin
                for (int c = 0; c < 3; c++) begin
                    r_cp[0][c] <= f_sat((60'(r_cp[1][c]) <<< 1) - 60'(r_cp[2][c]));
                    r_cp[4][c] <= f_sat((60'(r_cp[3][c]) <<< 1) - 60'(r_cp[2][c]));
                end
            end
            OP_H_TAKE: begin
                if (i_cmd.step[0]) begin
                    r_h <= r_h + signed'(w_mul_p[H_W-1:0]);
                end else begin
                    r_h <= w_mul_p[H_W-1:0];
                end
            end
            OP_DIV_START: begin
                r_neg <= r_h[H_W-1];
            end
            OP_DIV_TAKE: begin
                if (w_big) begin
                    r_pos[w_ax] <= r_neg ? SAT_LO[31:0] : SAT_HI[31:0];
                end else begin
                    r_pos[w_ax] <= f_sat(r_neg ? -w_q60 : w_q60);
                end
            end
            default: begin
                r_h <= r_h;
            end
        endcase
    end

    assign o_status.mul_done = w_mul_done;
    assign o_status.rt_done  = w_rt_done;
    assign o_status.div_done = w_div_done;
    assign o_status.last     = (r_idx == r_nm1);

    assign o_out_data.sample_index = r_idx;
    assign o_out_data.pos_x        = r_pos[0];
    assign o_out_data.pos_y        = r_pos[1];
    assign o_out_data.pos_z        = r_pos[2];
    assign o_out_data.last_sample  = (r_idx == r_nm1);

endmodule

// ===== hdl/srs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sagging rope sampler controller
// Sequences the set-up, the per-axis Horner steps, the divisions and the output.
// ----------------------------------------------------------------------------
module srs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  srs_pkg::t_status i_status,
    output srs_pkg::t_cmd    o_cmd
);
    import srs_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_axis, n_axis;
    logic [2:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= 2'd0;
            r_step  <= 3'd0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SQ_S;
                    n_axis  = 2'd0;
                    n_step  = 3'd0;
                end
            end
            S_SQ_S:  n_state = S_SQ_W;
            S_SQ_W: begin
                if (i_status.mul_done) begin
                    if (r_axis == AXIS_LAST) begin
                        n_state = S_RT_S;
                        n_axis  = 2'd0;
                    end else begin
                        n_state = S_SQ_S;
                        n_axis  = r_axis + 2'd1;
                    end
                end
            end
            S_RT_S:  n_state = S_RT_W;
            S_RT_W: begin
                if (i_status.rt_done) begin
                    n_state = S_D3_S;
                end
            end
            S_D3_S:  n_state = S_D3_W;
            S_D3_W: begin
                if (i_status.mul_done) begin
                    n_state = S_SAG_S;
                end
            end
            S_SAG_S: n_state = S_SAG_W;
            S_SAG_W: begin
                if (i_status.mul_done) begin
                    n_state = S_VEL_S;
                end
            end
            S_VEL_S: n_state = S_VEL_W;
            S_VEL_W: begin
                if (i_status.mul_done) begin
                    if (r_axis == AXIS_LAST) begin
                        n_state = S_ENDS;
                        n_axis  = 2'd0;
                    end else begin
                        n_state = S_SAG_S;
                        n_axis  = r_axis + 2'd1;
                    end
                end
            end
            S_ENDS: begin
                n_state = S_H_S;
                n_step  = 3'd0;
            end
            S_H_S:   n_state = S_H_W;
            S_H_W: begin
                if (i_status.mul_done) begin
                    if (r_step == STEP_LAST) begin
                        n_state = S_DIV_S;
                        n_step  = 3'd0;
                    end else begin
                        n_state = S_H_S;
                        n_step  = r_step + 3'd1;
                    end
                end
            end
            S_DIV_S: n_state = S_DIV_W;
            S_DIV_W: begin
                if (i_status.div_done) begin
                    if (r_axis == AXIS_LAST) begin
                        n_state = S_OUT;
                        n_axis  = 2'd0;
                    end else begin
                        n_state = S_H_S;
                        n_axis  = r_axis + 2'd1;
                    end
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = i_status.last ? S_IDLE : S_H_S;
                    n_axis  = 2'd0;
                    n_step  = 3'd0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.op    = OP_NONE;
        o_cmd.axis  = r_axis;
        o_cmd.step  = r_step;
        o_in_stall  = (r_state != S_IDLE);
        o_out_valid = (r_state == S_OUT);
        case (r_state)
            S_IDLE:  o_cmd.op = i_in_valid ? OP_LOAD : OP_NONE;
            S_SQ_S:  o_cmd.op = OP_SQ_START;
            S_SQ_W:  o_cmd.op = i_status.mul_done ? OP_SQ_TAKE : OP_NONE;
            S_RT_S:  o_cmd.op = OP_RT_START;
            S_RT_W:  o_cmd.op = i_status.rt_done ? OP_RT_TAKE : OP_NONE;
            S_D3_S:  o_cmd.op = OP_D3_START;
            S_D3_W:  o_cmd.op = i_status.mul_done ? OP_D3_TAKE : OP_NONE;
            S_SAG_S: o_cmd.op = OP_SAG_START;
            S_SAG_W: o_cmd.op = i_status.mul_done ? OP_SAG_TAKE : OP_NONE;
            S_VEL_S: o_cmd.op = OP_VEL_START;
            S_VEL_W: o_cmd.op = i_status.mul_done ? OP_VEL_TAKE : OP_NONE;
            S_ENDS:  o_cmd.op = OP_ENDS;
            S_H_S:   o_cmd.op = OP_H_START;
            S_H_W:   o_cmd.op = i_status.mul_done ? OP_H_TAKE : OP_NONE;
            S_DIV_S: o_cmd.op = OP_DIV_START;
            S_DIV_W: o_cmd.op = i_status.div_done ? OP_DIV_TAKE : OP_NONE;
            S_OUT:   o_cmd.op = i_out_stall ? OP_NONE : OP_NEXT;
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== hdl/sagging_rope_spline_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sagging rope spline sampler
// Builds five control points for a sagging rope and emits Catmull-Rom samples.
// ----------------------------------------------------------------------------
// Each input transfer carries the rope's start and end points, a sag
// direction and a ball velocity in signed Q16.16. The block forms a middle
// control point from the rope length (an exact floor square root), lowers and
// pulls it by 0.03 of that length and shifts it by 0.05 of the velocity, adds
// two mirrored outer points, and then emits seg_count output transfers, one
// per sample, evenly spaced over two Catmull-Rom spans; the final one carries
// last_sample. Every sample is the exact rational spline value rounded once
// and saturated. One item is worked on at a time: the input is stalled from
// acceptance until the last sample has been transferred. Set-up is dominated
// by the bit-serial multiplier (one multiplier bit a cycle) and the square
// root. Each sample then needs, for each axis, six Horner multiplies on the
// shared multiplier and a restoring division; any output stall adds to the
// run of an item. The seg_count register may only be written while the block
// is idle; values outside 2 to the sample limit are clamped.
// ----------------------------------------------------------------------------
module sagging_rope_spline_sampler #(
    parameter int MAX_SEGMENTS = 64,
    parameter int COORD_BITS   = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [6:0]    i_cfg_wdata,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  srs_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output srs_pkg::t_out o_out_data
);
    import srs_pkg::*;

    // Commands run from the controller to the datapath, status back.
    t_cmd    w_cmd;
    t_status w_status;

    srs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the configuration register, the captured input,
    // the control points and the registered output sample, which stays
    // unchanged while the output transfer is stalled.
    srs_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== sim/srs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sagging rope sampler checker
// Observes both channels, predicts every sample and compares it field by field.
// ----------------------------------------------------------------------------
module srs_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [6:0]    i_cfg_wdata,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  srs_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  srs_pkg::t_out i_out_data,
    output int            o_errors,
    output int            o_pending
);
    import srs_pkg::*;

    typedef logic signed [127:0] wide_t;

    localparam longint Q003 = 128849019;
    localparam longint Q005 = 214748365;

    logic [6:0] seg_setting;
    t_out       sample_queue[$];

    assign o_pending = sample_queue.size();

    function automatic wide_t clamp32(wide_t v);
        if (v > 128'sd2147483647) return 128'sd2147483647;
        if (v < -128'sd2147483648) return -128'sd2147483648;
        return v;
    endfunction

    // Divide by 2^s, ties rounded upwards.
    function automatic wide_t shr_half_up(wide_t x, int s);
        return (x + (128'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic wide_t catmull(wide_t p0, wide_t p1, wide_t p2, wide_t p3,
                                      wide_t a, wide_t d);
        wide_t ca, cb, cc, d2, d3, num, den;
        ca  = p2 - p0;
        cb  = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        cc  = 3 * p1 - p0 - 3 * p2 + p3;
        d2  = d * d;
        d3  = d2 * d;
        num = 2 * p1 * d3 + ca * a * d2 + cb * a * a * d + cc * a * a * a;
        den = 2 * d3;
        // Final division rounds half away from zero.
        if (num >= 0) return clamp32((num + d3) / den);
        return clamp32(-((-num + d3) / den));
    endfunction

    task automatic predict_samples(t_in item);
        wide_t       st[3], en[3], sg[3], vl[3], cp[15];
        logic [127:0] sq_sum, root, cand, diff;
        wide_t       rope_len, d3, mid, a, d, n;
        int          base;
        t_out        smp;
        st = '{wide_t'(item.start_x), wide_t'(item.start_y), wide_t'(item.start_z)};
        en = '{wide_t'(item.end_x), wide_t'(item.end_y), wide_t'(item.end_z)};
        sg = '{wide_t'(item.sag_x), wide_t'(item.sag_y), wide_t'(item.sag_z)};
        vl = '{wide_t'(item.vel_x), wide_t'(item.vel_y), wide_t'(item.vel_z)};
        sq_sum = '0;
        for (int c = 0; c < 3; c++) begin
            diff = (en[c] >= st[c]) ? en[c] - st[c] : st[c] - en[c];
            sq_sum += diff * diff;
        end
        // Floor square root, one result bit at a time.
        root = '0;
        for (int b = 34; b >= 0; b--) begin
            cand = root | (128'd1 << b);
            if (cand * cand <= sq_sum) root = cand;
        end
        rope_len = wide_t'(root);
        d3       = shr_half_up(rope_len * Q003, 32);
        for (int c = 0; c < 3; c++) begin
            mid = shr_half_up(st[c] + en[c], 1);
            if (c == 1) mid -= d3;
            mid -= shr_half_up(sg[c] * d3, 16);
            mid -= shr_half_up(vl[c] * Q005, 32);
            cp[3 + c] = clamp32(st[c]);
            cp[6 + c] = clamp32(mid);
            cp[9 + c] = clamp32(en[c]);
        end
        for (int c = 0; c < 3; c++) begin
            cp[c]      = clamp32(2 * cp[3 + c] - cp[6 + c]);
            cp[12 + c] = clamp32(2 * cp[9 + c] - cp[6 + c]);
        end
        n = wide_t'(seg_setting);
        if (n < 2) n = 2;
        if (n > 64) n = 64;
        d = n - 1;
        for (int i = 0; i < n; i++) begin
            // The first span covers the parameters below the middle sample.
            if (2 * i < d) begin
                a    = wide_t'(2 * i);
                base = 0;
            end else begin
                a    = wide_t'(2 * i) - d;
                base = 3;
            end
            smp.sample_index = i[5:0];
            smp.pos_x = 32'(catmull(cp[base], cp[base + 3], cp[base + 6], cp[base + 9],
                                    a, d));
            smp.pos_y = 32'(catmull(cp[base + 1], cp[base + 4], cp[base + 7],
                                    cp[base + 10], a, d));
            smp.pos_z = 32'(catmull(cp[base + 2], cp[base + 5], cp[base + 8],
                                    cp[base + 11], a, d));
            smp.last_sample = (i == n - 1);
            sample_queue = {sample_queue, smp};
        end
    endtask

    task automatic report_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_errors++;
        end
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            seg_setting = 7'd16;
        end else begin
            if (i_cfg_we) seg_setting = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) predict_samples(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (sample_queue.size() == 0) begin
                    $error("unexpected sample transfer, index %0d",
                           i_out_data.sample_index);
                    o_errors++;
                end else begin
                    want = sample_queue.pop_front();
                    report_field("sample_index", want.sample_index,
                                 i_out_data.sample_index);
                    report_field("pos_x", want.pos_x, i_out_data.pos_x);
                    report_field("pos_y", want.pos_y, i_out_data.pos_y);
                    report_field("pos_z", want.pos_z, i_out_data.pos_z);
                    report_field("last_sample", want.last_sample,
                                 i_out_data.last_sample);
                end
            end
        end
    end

endmodule

// ===== sim/sagging_rope_spline_sampler_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sagging rope sampler testbench
// Drives rope updates and sample-count settings; the checker judges results.
// ----------------------------------------------------------------------------
module sagging_rope_spline_sampler_test;
    import srs_pkg::*;

    // Generous bound on the whole run: set-up plus a full run of samples for every item, with stalls.
    localparam int CYCLE_LIMIT = 10000000;
    // Start and length of the long receiver hold-off, in cycles.
    localparam int HOLD_START  = 2000;
    localparam int HOLD_LEN    = 3000;
    // Window in which neither side idles.
    localparam int QUIET_START = 60000;
    localparam int QUIET_END   = 140000;

    logic  i_clk;
    logic  i_rst_n;
    logic  cfg_we;
    logic  [6:0] cfg_wdata;
    logic  in_valid;
    logic  in_stall;
    t_in   in_data;
    logic  out_valid;
    logic  out_stall;
    t_out  out_data;
    int    error_count;
    int    samples_pending;
    int    cycle_count;
    logic  quiet;

    sagging_rope_spline_sampler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    srs_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_errors    (error_count),
        .o_pending   (samples_pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // The cycle counter doubles as the watchdog. A timeout is a failure.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    assign quiet = (cycle_count >= QUIET_START) && (cycle_count < QUIET_END);

    // The receiver stalls at random, except in the quiet window. Once, early on,
    // it holds off for a long stretch so that the block fills and stalls its
    // input while the sender keeps offering the next transfer.
    initial out_stall = 1'b1;
    always @(negedge i_clk) begin
        if (cycle_count >= HOLD_START && cycle_count < HOLD_START + HOLD_LEN)
            out_stall <= 1'b1;
        else if (quiet)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 12);
    end

    // A coordinate drawn from one of three families: plausible scene values a
    // few units across, the saturation corners or zero, or any 32-bit pattern.
    function automatic logic [31:0] pick_coord();
        int unsigned mode;
        mode = $urandom_range(9);
        if (mode < 6) return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
        if (mode < 7) begin
            case ($urandom_range(2))
                0:       return 32'h80000000;
                1:       return 32'h7fffffff;
                default: return 32'h00000000;
            endcase
        end
        return $urandom;
    endfunction

    function automatic t_in random_rope();
        t_in r;
        r = {pick_coord(), pick_coord(), pick_coord(), pick_coord(),
             pick_coord(), pick_coord(), pick_coord(), pick_coord(),
             pick_coord(), pick_coord(), pick_coord(), pick_coord()};
        // Now and then the rope collapses to a point, giving zero length.
        if ($urandom_range(15) == 0) begin
            r.end_x = r.start_x;
            r.end_y = r.start_y;
            r.end_z = r.start_z;
        end
        return r;
    endfunction

    // Offers one rope update and returns just after the falling edge that
    // follows its acceptance, with valid still high.
    task automatic send_rope(t_in item);
        while (!quiet && $urandom_range(99) < 12) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Waits for every expected sample, then lets the block go idle, and only
    // then writes the sample count.
    task automatic set_seg_count(logic [6:0] value);
        in_valid <= 1'b0;
        while (samples_pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        t_in rope;
        i_rst_n   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at the reset count of sixteen: a rope at the origin,
        // both saturation corners, a zero-length rope with a strong sag and
        // mixed corners that drive the control points into saturation.
        send_rope('0);
        send_rope({12{32'h7fffffff}});
        send_rope({12{32'h80000000}});
        rope = '0;
        rope.start_x = 32'h00030000;
        rope.end_x   = 32'h00030000;
        rope.sag_y   = 32'h7fffffff;
        rope.vel_z   = 32'h80000000;
        send_rope(rope);
        send_rope({32'h80000000, 32'h7fffffff, 32'h80000000,
                   32'h7fffffff, 32'h80000000, 32'h7fffffff,
                   32'h7fffffff, 32'h80000000, 32'h7fffffff,
                   32'h80000000, 32'h7fffffff, 32'h80000000});
        rope = '0;
        rope.end_x = 32'h000a0000;
        rope.sag_y = 32'hffff0000;
        send_rope(rope);

        // Counts below two behave as two.
        set_seg_count(7'd0);
        send_rope(rope);
        send_rope({12{32'h55555555}});
        set_seg_count(7'd1);
        send_rope({12{32'haaaaaaaa}});
        set_seg_count(7'd2);
        send_rope(random_rope());
        // Counts above the sample limit behave as the limit.
        set_seg_count(7'd127);
        send_rope(random_rope());
        set_seg_count(7'd64);
        send_rope(rope);
        set_seg_count(7'd3);
        send_rope(random_rope());
        send_rope(random_rope());

        // Random part: small counts from 2 to 8, a change every twenty updates.
        for (int k = 0; k < 96; k++) begin
            if (k % 20 == 0) begin
                if (k == 60) set_seg_count(7'd2);
                else set_seg_count(7'($urandom_range(2, 8)));
            end
            send_rope(random_rope());
        end

        in_valid <= 1'b0;
        while (samples_pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/srs_pkg.sv
hdl/srs_mul.sv
hdl/srs_sqrt.sv
hdl/srs_div.sv
hdl/srs_dp.sv
hdl/srs_ctrl.sv
hdl/sagging_rope_spline_sampler.sv
sim/srs_checker.sv
sim/sagging_rope_spline_sampler_test.sv
